/* rtl/pud_pkg.sv */
package pud_pkg;

  // Escape introducer character.
  localparam logic [7:0] PERCENT_CHAR = 8'h25;

  // Mask for one hex digit.
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Value of the letter digits: 'a' and 'A' have low nibble 1 and map to 10.
  localparam logic [3:0] LETTER_BASE = 4'd10;
  localparam logic [3:0] LETTER_LOW  = 4'd1;

  // One queued work entry: one or two output beats produced by one input beat.
  typedef struct packed {
    logic       second_valid;
    logic [7:0] first_byte;
    logic       first_last;
    logic [7:0] second_byte;
    logic       second_last;
  } pud_entry_t;

  localparam int ENTRY_WIDTH = $bits(pud_entry_t);

endpackage

/* rtl/pud_in_if.sv */
interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/pud_out_if.sv */
interface pud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* rtl/pud_front.sv */
module pud_front (
  input  logic                clk,
  input  logic                rst,
  pud_in_if.sink              in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output pud_pkg::pud_entry_t push_data
);
  import pud_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic       has_result;
  logic       accept;
  logic [3:0] digit;

  // Map one character to its hex digit value; anything that is not a digit is zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = '0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = (c[3:0] - LETTER_LOW + LETTER_BASE) & NIBBLE_MASK;
    end
    return v;
  endfunction

  assign digit  = hex_value(in_ch.in_byte);
  assign accept = in_ch.valid && in_ch.ready;

  // The front stalls only when the queue has no room.
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && has_result;

  // Classify the beat and build the entry for the back end.
  always_comb begin
    phase_next                = PH_IDLE;
    high_nibble_next          = high_nibble;
    has_result                = 1'b1;
    push_data.second_valid    = 1'b0;
    push_data.first_byte      = in_ch.in_byte;
    push_data.first_last      = in_ch.in_last;
    push_data.second_byte     = in_ch.in_byte;
    push_data.second_last     = in_ch.in_last;
    case (phase)
      PH_PCT: begin
        if (in_ch.in_last) begin
          // Buffer ends after the first digit: emit '%' and the byte as is.
          push_data.second_valid = 1'b1;
          push_data.first_byte   = PERCENT_CHAR;
          push_data.first_last   = 1'b0;
        end else begin
          has_result       = 1'b0;
          high_nibble_next = digit;
          phase_next       = PH_HIGH;
        end
      end
      PH_HIGH: begin
        push_data.first_byte = {high_nibble, digit};
        high_nibble_next     = '0;
      end
      default: begin
        if (in_ch.in_byte == PERCENT_CHAR && !in_ch.in_last) begin
          has_result = 1'b0;
          phase_next = PH_PCT;
        end
      end
    endcase
  end

  // Escape state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A percent that is not the final byte opens an escape.
  a_pct_opens: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && in_ch.in_byte == PERCENT_CHAR && !in_ch.in_last
    |=> phase == PH_PCT)
    else $error("percent did not open an escape");
`endif

endmodule

/* rtl/pud_queue.sv */
module pud_queue #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count overflow");

  // A lone push grows the count by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

/* rtl/pud_back.sv */
module pud_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  pud_pkg::pud_entry_t pop_data,
  pud_out_if.source           out_ch
);
  import pud_pkg::*;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       pend_last;
  logic       load;

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.out_last = out_last;

  // The output register takes a new beat when empty or being drained.
  assign load      = !out_valid || out_ch.ready;
  assign pop_ready = load && !pend_valid;

  // Output register and the held second beat of a two-beat entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= pop_valid;
        pend_valid <= pop_valid && pop_data.second_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_byte <= pend_byte;
        out_last <= pend_last;
      end else if (pop_valid) begin
        out_byte  <= pop_data.first_byte;
        out_last  <= pop_data.first_last;
        pend_byte <= pop_data.second_byte;
        pend_last <= pop_data.second_last;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A held second beat always sits behind a shown first beat.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second beat held without first beat");

  // The held second beat moves out as soon as the first beat is taken.
  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    pend_valid && out_ch.ready |=> !pend_valid && out_valid)
    else $error("second beat did not advance");
`endif

endmodule

/* rtl/percent_url_decoder_top.sv */
// Channel   Direction  Beat payload          Handshake
// in_ch     sink       in_byte[7:0], in_last valid/ready
// out_ch    source     out_byte[7:0], out_last valid/ready
//
// One input beat is taken every cycle while the entry queue has room.
// A beat's output beats pass through a queue slot and then the output register;
// a two-beat result (percent left open at the end of a buffer) holds the
// output register for both beats, which the queue absorbs.
// Reset is synchronous and clears the escape state, the queue and the output.
// Output stalls fill the QUEUE_DEPTH-entry queue before the input stalls.
module percent_url_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  pud_in_if.sink     in_ch,
  pud_out_if.source  out_ch
);
  import pud_pkg::*;

  logic       push_valid;
  logic       push_ready;
  pud_entry_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  pud_entry_t pop_data;

  // Classification and escape tracking.
  pud_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Entry queue between front and back.
  pud_queue #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Output sequencing.
  pud_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
